// ===== hdl/lzfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzfd_pkg
// Shared types and constants of the LZ77 fast decompressor.
// ----------------------------------------------------------------------------
package lzfd_pkg;

  localparam int unsigned CNT_W   = 20;
  localparam int unsigned CTRL_LIT_MAX = 31;
  localparam int unsigned LEN_EXT_CODE = 6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BADREF   = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_CTRL,
    PH_LIT,
    PH_LEN,
    PH_DIST,
    PH_COPY_RD,
    PH_COPY,
    PH_EMIT
  } phase_t;

endpackage

// ===== hdl/lzfd_in_if.sv =====
// ----------------------------------------------------------------------------
// lzfd_in_if
// Compressed byte channel.
// ----------------------------------------------------------------------------
interface lzfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_first;
  logic       in_last;
  modport source (output valid, in_byte, in_first, in_last, input ready);
  modport sink (input valid, in_byte, in_first, in_last, output ready);
endinterface

// ===== hdl/lzfd_out_if.sv =====
// ----------------------------------------------------------------------------
// lzfd_out_if
// Decompressed result channel.
// ----------------------------------------------------------------------------
interface lzfd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        out_last;
  logic [1:0]  status;
  logic [19:0] total_length;
  modport source (output valid, out_data, out_count, out_last, status, total_length,
                  input ready);
  modport sink (input valid, out_data, out_count, out_last, status, total_length,
                output ready);
endinterface

// ===== hdl/lzfd_ram.sv =====
// ----------------------------------------------------------------------------
// lzfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/lz77_fast_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz77_fast_decompressor
// Streaming FastLZ level-1 decompressor with a history RAM.
// ----------------------------------------------------------------------------
// Compressed bytes arrive on in_ch, one per transaction; results leave on
// out_ch, each holding up to BYTES_PER_RESULT decompressed bytes with the
// first byte in the low bits. max_out is written through cfg_we/cfg_wdata,
// by the user only while the block is idle; the block does not enforce it.
// A control, length or distance byte gives no result by itself.
// A literal byte gives a single-byte result in the cycle after its acceptance.
// A match copy reads the history RAM through its single read port. Each byte
// passes through a read state and a write state, since the byte just written
// may be the next one read, and each full or final result is handed over in
// an emit state; input is not ready during the copy.
// An error gives one empty result with out_last.
// When the receiver stalls, the pending result is held in the output
// register and the block waits. Reset returns to expecting a control byte,
// max_out to 65535; the history RAM is not cleared, as references can only
// reach bytes written in the current frame.
// ----------------------------------------------------------------------------
module lz77_fast_decompressor
  import lzfd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES     = 8192,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  lzfd_in_if.sink     in_ch,
  lzfd_out_if.source  out_ch
);
  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned FW = $clog2(BYTES_PER_RESULT + 1);

  phase_t       phase, phase_next;
  logic [19:0]  max_out;
  logic [19:0]  produced, produced_next;
  logic [5:0]   literal_left, literal_left_next;
  logic [8:0]   match_length, match_length_next;
  logic [4:0]   offset_high, offset_high_next;
  logic         error_latched, error_latched_next;
  logic         last_q, last_q_next;
  logic [8:0]   copy_left, copy_left_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [FW-1:0] fill, fill_next;
  logic [63:0]  acc, acc_next;

  logic         ov, ov_next;
  logic [63:0]  o_data, o_data_next;
  logic [3:0]   o_count, o_count_next;
  logic         o_last, o_last_next;
  status_t      o_status, o_status_next;
  logic [19:0]  o_total, o_total_next;

  logic         we;
  logic [AW-1:0] waddr;
  logic [7:0]   wdata, rdata;

  lzfd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rd_ptr), .rdata(rdata)
  );

  assign in_ch.ready = (phase == PH_CTRL || phase == PH_LIT || phase == PH_LEN ||
                        phase == PH_DIST) && !ov;
  assign out_ch.valid        = ov;
  assign out_ch.out_data     = o_data;
  assign out_ch.out_count    = o_count;
  assign out_ch.out_last     = o_last;
  assign out_ch.status       = o_status;
  assign out_ch.total_length = o_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CTRL;
      max_out <= 20'd65535;
      produced <= '0;
      literal_left <= '0;
      match_length <= '0;
      offset_high <= '0;
      error_latched <= 1'b0;
      ov <= 1'b0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        max_out <= cfg_wdata;
      end
      produced <= produced_next;
      literal_left <= literal_left_next;
      match_length <= match_length_next;
      offset_high <= offset_high_next;
      error_latched <= error_latched_next;
      ov <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    last_q <= last_q_next;
    copy_left <= copy_left_next;
    rd_ptr <= rd_ptr_next;
    fill <= fill_next;
    acc <= acc_next;
    o_data <= o_data_next;
    o_count <= o_count_next;
    o_last <= o_last_next;
    o_status <= o_status_next;
    o_total <= o_total_next;
  end

  always_comb begin
    logic [7:0]  b;
    logic        lst;
    logic [20:0] need;
    logic [13:0] back_ref;
    logic [63:0] acc_w;
    logic        done;
    phase_next = phase;
    produced_next = produced;
    literal_left_next = literal_left;
    match_length_next = match_length;
    offset_high_next = offset_high;
    error_latched_next = error_latched;
    last_q_next = last_q;
    copy_left_next = copy_left;
    rd_ptr_next = rd_ptr;
    fill_next = fill;
    acc_next = acc;
    ov_next = ov && !out_ch.ready;
    o_data_next = o_data;
    o_count_next = o_count;
    o_last_next = o_last;
    o_status_next = o_status;
    o_total_next = o_total;
    we = 1'b0;
    waddr = produced[AW-1:0];
    wdata = in_ch.in_byte;
    b = in_ch.in_byte;
    lst = in_ch.in_last;
    need = '0;
    back_ref = '0;
    acc_w = acc;
    done = 1'b0;

    if (in_ch.valid && in_ch.ready) begin
      phase_next = phase;
      if (in_ch.in_first) begin
        produced_next = '0;
        error_latched_next = 1'b0;
        phase_next = PH_CTRL;
        literal_left_next = '0;
        match_length_next = '0;
        offset_high_next = '0;
        b = {3'b000, in_ch.in_byte[4:0]};
      end
      if (!error_latched_next) begin
        // Error result template; data and count are zero.
        o_data_next = '0;
        o_count_next = '0;
        o_last_next = 1'b1;
        o_total_next = produced_next;
        case (phase_next)
          PH_CTRL: begin
            if (b <= 8'(CTRL_LIT_MAX)) begin
              need = 21'(produced_next) + 21'(b) + 21'd1;
              if (need > 21'(max_out)) begin
                ov_next = 1'b1; o_status_next = ST_OVERFLOW;
                error_latched_next = 1'b1; phase_next = PH_CTRL;
              end else if (lst) begin
                ov_next = 1'b1; o_status_next = ST_TRUNC;
                error_latched_next = 1'b1; phase_next = PH_CTRL;
              end else begin
                literal_left_next = 6'(b) + 6'd1;
                phase_next = PH_LIT;
              end
            end else begin
              offset_high_next = b[4:0];
              match_length_next = 9'(b[7:5]) - 9'd1;
              if (lst) begin
                ov_next = 1'b1; o_status_next = ST_TRUNC;
                error_latched_next = 1'b1; phase_next = PH_CTRL;
              end else begin
                phase_next = (b[7:5] == 3'd7) ? PH_LEN : PH_DIST;
              end
            end
          end
          PH_LEN: begin
            match_length_next = 9'(LEN_EXT_CODE) + 9'(b);
            if (lst) begin
              ov_next = 1'b1; o_status_next = ST_TRUNC;
              error_latched_next = 1'b1; phase_next = PH_CTRL;
            end else begin
              phase_next = PH_DIST;
            end
          end
          PH_LIT: begin
            we = 1'b1;
            waddr = produced_next[AW-1:0];
            wdata = b;
            produced_next = produced_next + 20'd1;
            literal_left_next = literal_left_next - 6'd1;
            ov_next = 1'b1;
            o_total_next = produced_next;
            if (literal_left_next == '0) begin
              phase_next = PH_CTRL;
              o_data_next = 64'(b); o_count_next = 4'd1;
              o_last_next = lst; o_status_next = ST_OK;
              if (lst) error_latched_next = 1'b1;
            end else if (lst) begin
              o_status_next = ST_TRUNC; o_last_next = 1'b1;
              error_latched_next = 1'b1; phase_next = PH_CTRL;
            end else begin
              o_data_next = 64'(b); o_count_next = 4'd1;
              o_last_next = 1'b0; o_status_next = ST_OK;
            end
          end
          default: begin
            // Distance byte: check, then start the copy sequence.
            need = 21'(produced_next) + 21'(match_length_next) + 21'd3;
            back_ref = 14'({offset_high_next, b}) + 14'd1;
            if (need > 21'(max_out)) begin
              ov_next = 1'b1; o_status_next = ST_OVERFLOW;
              error_latched_next = 1'b1; phase_next = PH_CTRL;
            end else if (20'(back_ref) > produced_next) begin
              ov_next = 1'b1; o_status_next = ST_BADREF;
              error_latched_next = 1'b1; phase_next = PH_CTRL;
            end else begin
              copy_left_next = match_length_next + 9'd3;
              rd_ptr_next = AW'(produced_next - 20'(back_ref));
              last_q_next = lst;
              fill_next = '0;
              acc_next = '0;
              phase_next = PH_COPY_RD;
            end
          end
        endcase
      end
    end else begin
      case (phase)
        PH_COPY_RD: begin
          phase_next = PH_COPY;
        end
        PH_COPY: begin
          // rdata holds the byte at the current rd_ptr.
          we = 1'b1;
          waddr = produced[AW-1:0];
          wdata = rdata;
          produced_next = produced + 20'd1;
          acc_w = acc | (64'(rdata) << (6'(fill) * 6'd8));
          acc_next = acc_w;
          fill_next = fill + FW'(1);
          copy_left_next = copy_left - 9'd1;
          rd_ptr_next = rd_ptr + AW'(1);
          done = (copy_left == 9'd1);
          // A byte just written may be the next one read; re-read after a write.
          phase_next = PH_COPY_RD;
          if (done || fill_next == FW'(BYTES_PER_RESULT)) begin
            phase_next = PH_EMIT;
          end
        end
        PH_EMIT: begin
          if (!ov) begin
            ov_next = 1'b1;
            o_data_next = acc;
            o_count_next = 4'(fill);
            o_status_next = ST_OK;
            o_total_next = produced;
            o_last_next = last_q && (copy_left == '0);
            acc_next = '0;
            fill_next = '0;
            if (copy_left == '0) begin
              phase_next = PH_CTRL;
              if (last_q) error_latched_next = 1'b1;
            end else begin
              phase_next = PH_COPY_RD;
            end
          end
        end
        default: ;
      endcase
    end
  end

  property p_no_accept_when_busy;
    @(posedge clk) disable iff (rst)
      (phase == PH_COPY || phase == PH_COPY_RD || phase == PH_EMIT) |-> !in_ch.ready;
  endproperty
  a_no_accept_when_busy: assert property (p_no_accept_when_busy)
    else $error("input accepted during a match copy");

  property p_count_range;
    @(posedge clk) disable iff (rst)
      out_ch.valid |-> (out_ch.out_count <= 4'(BYTES_PER_RESULT));
  endproperty
  a_count_range: assert property (p_count_range)
    else $error("result byte count out of range");

  property p_error_empty;
    @(posedge clk) disable iff (rst)
      (out_ch.valid && out_ch.status != ST_OK) |->
        (out_ch.out_count == 4'd0 && out_ch.out_last);
  endproperty
  a_error_empty: assert property (p_error_empty)
    else $error("error result carries data");
endmodule

// ===== tb/sv/lzfd_tb_if.sv =====
// ----------------------------------------------------------------------------
// lzfd_tb_if
// Testbench types of the decompressor checker.
// ----------------------------------------------------------------------------
// Holds the decoder phases of the predictor and the packed result record
// that the scoreboard compares.
// ----------------------------------------------------------------------------
package lzfd_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder phases as the predictor sees them.
  typedef enum int {
    DP_CTRL,
    DP_LIT,
    DP_LEN,
    DP_DIST
  } dphase_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [1:0]  status;
    logic [19:0] total;
  } result_t;
endpackage

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the LZ77 fast decompressor.
// ----------------------------------------------------------------------------
// Well-formed frames with random literals and matches are streamed in, along
// with broken frames, restarts and stray bytes. A behavioral decoder predicts
// every result; results are compared in order, field by field. Both channels
// idle at random, the receiver once holds off for a long stretch, and max_out
// is changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import lzfd_pkg::*;
  import lzfd_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 8192;
  localparam int WDOG_LIMIT = 20000;

  class lz_scoreboard;
    logic [7:0]  hist [WIN];
    logic [19:0] produced;
    dphase_t     ph;
    int          lit_left;
    int          mlen;
    int          off_hi;
    bit          halted;
    logic [19:0] max_out;
    result_t     pending [$];
    int          mismatches;
    int          results_seen;

    function new();
      produced = 0;
      ph = DP_CTRL;
      lit_left = 0;
      mlen = 0;
      off_hi = 0;
      halted = 0;
      max_out = 20'd65535;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void push(logic [63:0] d, int c, bit l, status_t s);
      result_t r;
      r.data = d;
      r.count = c[3:0];
      r.last = l;
      r.status = s;
      r.total = produced;
      pending.push_back(r);
    endfunction

    function void abort(status_t s);
      halted = 1;
      ph = DP_CTRL;
      push(64'd0, 0, 1'b1, s);
    endfunction

    function void keep(logic [7:0] b);
      hist[produced % WIN] = b;
      produced = produced + 20'd1;
    endfunction

    // Notes one accepted compressed byte and queues the results it causes.
    function void note_input(logic [7:0] byte_in, bit first, bit last);
      int b;
      int n;
      int back_ref;
      int fill;
      logic [63:0] acc;
      logic [7:0] v;
      b = byte_in;
      if (first) begin
        produced = 0;
        halted = 0;
        ph = DP_CTRL;
        lit_left = 0;
        mlen = 0;
        off_hi = 0;
        b = b & CTRL_LIT_MAX;
      end
      if (halted) return;
      case (ph)
        DP_CTRL: begin
          if (b <= CTRL_LIT_MAX) begin
            if (int'(produced) + b + 1 > int'(max_out)) begin
              abort(ST_OVERFLOW);
              return;
            end
            if (last) begin
              abort(ST_TRUNC);
              return;
            end
            lit_left = b + 1;
            ph = DP_LIT;
          end else begin
            off_hi = b & 31;
            mlen = (b >> 5) - 1;
            if (last) begin
              abort(ST_TRUNC);
              return;
            end
            ph = (mlen == LEN_EXT_CODE) ? DP_LEN : DP_DIST;
          end
        end
        DP_LEN: begin
          mlen = LEN_EXT_CODE + b;
          if (last) begin
            abort(ST_TRUNC);
            return;
          end
          ph = DP_DIST;
        end
        DP_LIT: begin
          keep(b[7:0]);
          lit_left--;
          if (lit_left == 0) ph = DP_CTRL;
          else if (last) begin
            abort(ST_TRUNC);
            return;
          end
          if (last) halted = 1;
          push({56'd0, b[7:0]}, 1, last, ST_OK);
        end
        default: begin
          n = mlen + 3;
          back_ref = off_hi * 256 + b + 1;
          if (int'(produced) + n > int'(max_out)) begin
            abort(ST_OVERFLOW);
            return;
          end
          if (back_ref > int'(produced)) begin
            abort(ST_BADREF);
            return;
          end
          ph = DP_CTRL;
          acc = 0;
          fill = 0;
          for (int i = 0; i < n; i++) begin
            v = hist[(int'(produced) - back_ref) % WIN];
            keep(v);
            acc = acc | (64'(v) << (8 * fill));
            fill++;
            if (fill == 8 || i + 1 == n) begin
              push(acc, fill, last && (i + 1 == n), ST_OK);
              acc = 0;
              fill = 0;
            end
          end
          if (last) halted = 1;
        end
      endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(result_t got);
      result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result data=%h count=%0d last=%0d st=%0d len=%0d",
                   got.data, got.count, got.last, got.status, got.total);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d exp data=%h cnt=%0d last=%0d st=%0d len=%0d,",
                    " got data=%h cnt=%0d last=%0d st=%0d len=%0d"},
                   results_seen, exp_r.data, exp_r.count, exp_r.last, exp_r.status,
                   exp_r.total, got.data, got.count, got.last, got.status, got.total);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;

  lzfd_in_if  in_ch ();
  lzfd_out_if out_ch ();

  lz77_fast_decompressor i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lz_scoreboard board;
  int  hold_off_cycles = 0;
  int  idle_cycles = 0;
  int  bytes_sent = 0;
  int  frames_sent = 0;
  bit  sink_quiet = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_first = 1'b0;
    in_ch.in_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Result side: random or steady ready, with one long hold-off on request.
  always @(posedge clk) begin
    result_t r;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        r.data = out_ch.out_data;
        r.count = out_ch.out_count;
        r.last = out_ch.out_last;
        r.status = out_ch.status;
        r.total = out_ch.total_length;
        board.check_result(r);
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ch.ready <= 1'b0;
      end else if (sink_quiet) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || hold_off_cycles > 0)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding",
                 board.pending.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit first, input bit last);
    int g;
    g = gap_len();
    if ($urandom_range(0, 3) == 0) g = 0;
    repeat (g) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_first <= first;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(b, first, last);
    bytes_sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Emits a well-formed frame of nops operations, possibly broken.
  task automatic send_frame(input int nops, input bit broken);
    int produced;
    int run;
    int len;
    int back_ref;
    int cut;
    int k;
    logic [7:0] seq [$];
    produced = 0;
    for (int op = 0; op < nops; op++) begin
      if (op == 0 || produced < 1 || $urandom_range(0, 2) == 0) begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
        seq.push_back(run[7:0]);
        for (int i = 0; i <= run; i++) seq.push_back(8'($urandom_range(0, 255)));
        produced += run + 1;
      end else begin
        // Short codes stop at 5, as code 7 always takes a length byte.
        len = $urandom_range(0, 4) == 0 ? $urandom_range(7, 40) : $urandom_range(1, 5);
        if ($urandom_range(0, 30) == 0) len = 6 + 255;
        back_ref = $urandom_range(1, produced > 8191 ? 8192 : produced);
        if ($urandom_range(0, 20) == 0) back_ref = produced + 1;
        if (back_ref > 8192) back_ref = 8192;
        back_ref = back_ref - 1;
        if (len >= 7) begin
          seq.push_back({3'd7, back_ref[12:8]});
          seq.push_back(8'(len - 6));
        end else seq.push_back({3'(len + 1), back_ref[12:8]});
        seq.push_back(back_ref[7:0]);
        produced += len + 3;
      end
    end
    cut = broken ? $urandom_range(1, seq.size()) : seq.size();
    for (k = 0; k < cut; k++) begin
      // The first byte is masked by the block; randomize its upper bits.
      if (k == 0) seq[0][7:5] = 3'($urandom_range(0, 7));
      send_byte(seq[k], k == 0, k == cut - 1);
    end
    frames_sent++;
  endtask

  task automatic drain();
    go_idle();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_max_out(input logic [19:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.max_out = v;
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Stray bytes after reset without a frame start.
    send_byte(8'h02, 0, 0);
    send_byte(8'hFF, 0, 0);
    send_byte(8'h00, 0, 0);
    send_byte(8'hA5, 0, 0);
    send_byte(8'h20, 0, 0);
    send_byte(8'h00, 0, 0);
    // Masked first byte, max literal run, extended match, clean end.
    send_byte(8'hFF, 1, 0);
    for (int i = 0; i < 32; i++) send_byte(8'(i * 8 + 7), 0, 0);
    send_byte(8'hE0, 0, 0);
    send_byte(8'hFF, 0, 0);
    send_byte(8'h1F, 0, 1);
    send_byte(8'h55, 0, 0);
    // Reference before start, truncations on each kind of byte.
    send_byte(8'h00, 1, 0);
    send_byte(8'h11, 0, 0);
    send_byte(8'h40, 0, 0);
    send_byte(8'h05, 0, 0);
    send_byte(8'h01, 1, 0);
    send_byte(8'h33, 0, 1);
    send_byte(8'h00, 1, 0);
    send_byte(8'h77, 0, 0);
    send_byte(8'hE0, 0, 0);
    send_byte(8'h00, 0, 1);
    send_byte(8'h00, 1, 1);
    drain();

    // Overflow cases with tiny limits, including zero.
    write_max_out(20'd0);
    send_byte(8'h00, 1, 0);
    drain();
    write_max_out(20'd3);
    send_frame(4, 0);
    drain();
    write_max_out(20'd40);
    for (int f = 0; f < 6; f++) send_frame($urandom_range(2, 8), 0);
    drain();
    write_max_out(20'hFFFFF);

    // Long receiver hold-off while the sender keeps going.
    hold_off_cycles = 400;
    send_frame(12, 0);
    drain();

    while (bytes_sent < 480) begin
      if (frames_sent % 25 == 0 && $urandom_range(0, 1) == 0) begin
        drain();
        write_max_out($urandom_range(0, 1) ? 20'd65535 : 20'($urandom_range(20, 300)));
      end
      if ($urandom_range(0, 9) == 0) sink_quiet = !sink_quiet;
      if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(0, 255)),
                                               $urandom_range(0, 3) == 0,
                                               $urandom_range(0, 3) == 0);
      else send_frame($urandom_range(1, 10), $urandom_range(0, 4) == 0);
    end
    drain();

    $display("Sent %0d compressed bytes in %0d frames; %0d results checked.",
             bytes_sent, frames_sent, board.results_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/lzfd_pkg.sv
hdl/lzfd_in_if.sv
hdl/lzfd_out_if.sv
hdl/lzfd_ram.sv
hdl/lz77_fast_decompressor.sv
tb/sv/lzfd_tb_if.sv
tb/sv/tb_top.sv
